[design/isa_bcd_pkg.sv]
// Shared types and constants for the ISA bus cycle decoder.
// No dependencies; all other design files but isa_bcd_outq use it by scoped names.
`timescale 1ns / 1ps

package isa_bcd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int CNT_W       = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ADDR_WIDTH_SEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE_DATA_EN   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WAIT_LIMIT     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_LIMIT    = 2'd3;

    // address width select codes
    localparam logic [1:0] AW_SEL_20 = 2'd1;
    localparam logic [1:0] AW_SEL_24 = 2'd2;

    localparam logic [CNT_W-1:0] WAIT_LIMIT_RST  = 8'd20;
    localparam logic [CNT_W-1:0] CYCLE_LIMIT_RST = 8'd10;

    // record kinds
    localparam logic [1:0] KIND_RESET   = 2'd0;
    localparam logic [1:0] KIND_CYCLE   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // cycle types
    localparam logic [3:0] TYPE_NONE      = 4'd0;
    localparam logic [3:0] TYPE_IO_RD_B   = 4'd1;
    localparam logic [3:0] TYPE_IO_RD_W   = 4'd2;
    localparam logic [3:0] TYPE_IO_WR_B   = 4'd3;
    localparam logic [3:0] TYPE_IO_WR_W   = 4'd4;
    localparam logic [3:0] TYPE_MEM_RD_B  = 4'd5;
    localparam logic [3:0] TYPE_MEM_RD_W  = 4'd6;
    localparam logic [3:0] TYPE_MEM_WR_B  = 4'd7;
    localparam logic [3:0] TYPE_MEM_WR_W  = 4'd8;
    localparam logic [3:0] TYPE_REFRESH   = 4'd9;

    typedef struct packed {
        logic [1:0]       addr_width_sel;
        logic             wide_data_en;
        logic [CNT_W-1:0] wait_limit;
        logic [CNT_W-1:0] cycle_limit;
    } t_cfg;

    // raw levels of the lines whose edges are tracked
    typedef struct packed {
        logic refresh_n;
        logic mem_write_n;
        logic mem_read_n;
        logic io_write_n;
        logic io_read_n;
        logic ale;
        logic bus_clock;
    } t_strobes;

    typedef struct packed {
        t_strobes lines;
        logic     byte_high_enable_n;
        logic     channel_ready;
        logic     bus_reset;
    } t_ctl;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic is_word_type(input logic [3:0] t);
        return (t == TYPE_IO_RD_W) || (t == TYPE_IO_WR_W) ||
               (t == TYPE_MEM_RD_W) || (t == TYPE_MEM_WR_W);
    endfunction

    function automatic logic is_read_type(input logic [3:0] t);
        return (t == TYPE_IO_RD_B) || (t == TYPE_IO_RD_W) ||
               (t == TYPE_MEM_RD_B) || (t == TYPE_MEM_RD_W);
    endfunction

    function automatic logic is_write_type(input logic [3:0] t);
        return (t == TYPE_IO_WR_B) || (t == TYPE_IO_WR_W) ||
               (t == TYPE_MEM_WR_B) || (t == TYPE_MEM_WR_W);
    endfunction

endpackage

[design/isa_bcd_if.sv]
// Channel interfaces of the ISA bus cycle decoder: sample input, record output, config write.
// Depends on isa_bcd_pkg for the config field widths.
`timescale 1ns / 1ps

interface isa_bcd_in_if #(
    parameter int ADDRESS_BITS = 24,
    parameter int DATA_BITS    = 16
);
    logic                    valid;
    logic                    ready;
    logic                    bus_clock;
    logic                    addr_latch_enable;
    logic                    io_read_n;
    logic                    io_write_n;
    logic                    mem_read_n;
    logic                    mem_write_n;
    logic                    refresh_n;
    logic                    byte_high_enable_n;
    logic                    channel_ready;
    logic                    bus_reset;
    logic [ADDRESS_BITS-1:0] address_lines;
    logic [DATA_BITS-1:0]    data_lines;

    modport source (
        output valid, bus_clock, addr_latch_enable, io_read_n, io_write_n, mem_read_n,
               mem_write_n, refresh_n, byte_high_enable_n, channel_ready, bus_reset,
               address_lines, data_lines,
        input  ready
    );
    modport sink (
        input  valid, bus_clock, addr_latch_enable, io_read_n, io_write_n, mem_read_n,
               mem_write_n, refresh_n, byte_high_enable_n, channel_ready, bus_reset,
               address_lines, data_lines,
        output ready
    );
endinterface

interface isa_bcd_out_if #(
    parameter int ADDRESS_BITS = 24,
    parameter int DATA_BITS    = 16,
    parameter int INDEX_BITS   = 32
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              record_kind;
    logic [3:0]              cycle_type;
    logic [INDEX_BITS-1:0]   start_index;
    logic [ADDRESS_BITS-1:0] latched_address;
    logic [DATA_BITS-1:0]    cycle_data;
    logic [7:0]              wait_count;
    logic [7:0]              clock_count;
    logic                    fault_flag;
    logic                    last_record;

    modport source (
        output valid, record_kind, cycle_type, start_index, latched_address, cycle_data,
               wait_count, clock_count, fault_flag, last_record,
        input  ready
    );
    modport sink (
        input  valid, record_kind, cycle_type, start_index, latched_address, cycle_data,
               wait_count, clock_count, fault_flag, last_record,
        output ready
    );
endinterface

interface isa_bcd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [isa_bcd_pkg::CFG_INDEX_W-1:0] index;
    logic [isa_bcd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/isa_bcd_cfg.sv]
// Configuration register file of the ISA bus cycle decoder.
// Depends on isa_bcd_pkg for the register indexes and the t_cfg struct.
`timescale 1ns / 1ps

module isa_bcd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [isa_bcd_pkg::CFG_INDEX_W-1:0] i_index,
    input  logic [isa_bcd_pkg::CFG_DATA_W-1:0]  i_data,
    output logic                                o_ready,
    output isa_bcd_pkg::t_cfg                   o_cfg
);

    isa_bcd_pkg::t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.addr_width_sel <= '0;
            r_cfg.wide_data_en   <= 1'b0;
            r_cfg.wait_limit     <= isa_bcd_pkg::WAIT_LIMIT_RST;
            r_cfg.cycle_limit    <= isa_bcd_pkg::CYCLE_LIMIT_RST;
        end else if (i_valid) begin
            case (i_index)
                isa_bcd_pkg::REG_ADDR_WIDTH_SEL: r_cfg.addr_width_sel <= i_data[1:0];
                isa_bcd_pkg::REG_WIDE_DATA_EN:   r_cfg.wide_data_en   <= i_data[0];
                isa_bcd_pkg::REG_WAIT_LIMIT:     r_cfg.wait_limit     <= i_data;
                isa_bcd_pkg::REG_CYCLE_LIMIT:    r_cfg.cycle_limit    <= i_data;
                default: begin
                end
            endcase
        end
    end

endmodule

[design/isa_bcd_core.sv]
// Sample register, edge detection and bus cycle state machine of the ISA decoder.
// Produces up to two packed records per sample. Depends on isa_bcd_pkg.
`timescale 1ns / 1ps

module isa_bcd_core #(
    parameter int ADDRESS_BITS = 24,
    parameter int DATA_BITS    = 16,
    parameter int INDEX_BITS   = 32,
    parameter int REC_W        = 2 + 4 + INDEX_BITS + ADDRESS_BITS + DATA_BITS + 8 + 8 + 1 + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  isa_bcd_pkg::t_cfg       i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  isa_bcd_pkg::t_ctl       i_ctl,
    input  logic [ADDRESS_BITS-1:0] i_addr,
    input  logic [DATA_BITS-1:0]    i_data,
    input  logic                    i_space,
    output logic [1:0]              o_push_cnt,
    output logic [REC_W-1:0]        o_rec0,
    output logic [REC_W-1:0]        o_rec1
);

    localparam int CW = isa_bcd_pkg::CNT_W;
    localparam logic [ADDRESS_BITS-1:0] AMASK_16 = ADDRESS_BITS'(16'hFFFF);
    localparam logic [ADDRESS_BITS-1:0] AMASK_20 = ADDRESS_BITS'(20'hFFFFF);
    localparam logic [ADDRESS_BITS-1:0] AMASK_24 = ADDRESS_BITS'(24'hFFFFFF);
    localparam logic [DATA_BITS-1:0]    BYTE_MASK = DATA_BITS'(8'hFF);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_T1      = 3'd1,
        PH_T2      = 3'd2,
        PH_TW      = 3'd3,
        PH_T3      = 3'd4,
        PH_REFRESH = 3'd5
    } t_phase;

    // sample register
    logic                    r_valid;
    isa_bcd_pkg::t_ctl       r_ctl;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [DATA_BITS-1:0]    r_data;

    // decoder state
    t_phase                  r_phase,      n_phase;
    logic [3:0]              r_type,       n_type;
    logic [INDEX_BITS-1:0]   r_start,      n_start;
    logic [INDEX_BITS-1:0]   r_sample;
    logic [ADDRESS_BITS-1:0] r_early,      n_early;
    logic [ADDRESS_BITS-1:0] r_held_addr,  n_held_addr;
    logic [DATA_BITS-1:0]    r_held_data,  n_held_data;
    logic                    r_captured,   n_captured;
    logic [CW-1:0]           r_waits,      n_waits;
    logic [CW-1:0]           r_clocks,     n_clocks;
    logic                    r_fault,      n_fault;
    isa_bcd_pkg::t_strobes   r_prev,       n_prev;

    logic                    w_fire;
    logic [1:0]              w_cnt;
    logic [REC_W-1:0]        w_recs [2];
    logic [ADDRESS_BITS-1:0] w_amask;
    logic [DATA_BITS-1:0]    w_data;
    logic                    w_sbhe, w_clk_rise, w_ale_rise, w_ale_fall;
    logic                    w_ior_fall, w_iow_fall, w_memr_fall, w_memw_fall;
    logic                    w_ref_fall, w_ref_rise, w_cmd_rise, w_any_fall;
    logic [DATA_BITS-1:0]    w_cyc_data;

    function automatic logic [REC_W-1:0] pack_rec(
        input logic [1:0]              kind,
        input logic [3:0]              ty,
        input logic [INDEX_BITS-1:0]   st,
        input logic [ADDRESS_BITS-1:0] ad,
        input logic [DATA_BITS-1:0]    da,
        input logic [CW-1:0]           wt,
        input logic [CW-1:0]           ck,
        input logic                    er
    );
        return {kind, ty, st, ad, da, wt, ck, er, 1'b0};
    endfunction

    function automatic logic [3:0] type_code(input logic [3:0] base, input logic wide,
                                              input logic sbhe);
        return (wide && sbhe) ? base + 4'd1 : base;
    endfunction

    assign w_fire  = r_valid && i_space;
    assign o_ready = !r_valid || i_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (w_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ctl  <= i_ctl;
            r_addr <= i_addr;
            r_data <= i_data;
        end
    end

    // address and data masks, and edge detection against the previous snapshot
    always_comb begin
        case (i_cfg.addr_width_sel)
            isa_bcd_pkg::AW_SEL_20: w_amask = AMASK_20;
            isa_bcd_pkg::AW_SEL_24: w_amask = AMASK_24;
            default:                w_amask = AMASK_16;
        endcase
        w_data      = i_cfg.wide_data_en ? r_data : (r_data & BYTE_MASK);
        w_sbhe      = !r_ctl.byte_high_enable_n;
        w_clk_rise  = r_ctl.lines.bus_clock && !r_prev.bus_clock;
        w_ale_rise  = r_ctl.lines.ale && !r_prev.ale;
        w_ale_fall  = !r_ctl.lines.ale && r_prev.ale;
        w_ior_fall  = !r_ctl.lines.io_read_n && r_prev.io_read_n;
        w_iow_fall  = !r_ctl.lines.io_write_n && r_prev.io_write_n;
        w_memr_fall = !r_ctl.lines.mem_read_n && r_prev.mem_read_n;
        w_memw_fall = !r_ctl.lines.mem_write_n && r_prev.mem_write_n;
        w_ref_fall  = !r_ctl.lines.refresh_n && r_prev.refresh_n;
        w_ref_rise  = r_ctl.lines.refresh_n && !r_prev.refresh_n;
        w_cmd_rise  = (r_ctl.lines.io_read_n && !r_prev.io_read_n) ||
                      (r_ctl.lines.io_write_n && !r_prev.io_write_n) ||
                      (r_ctl.lines.mem_read_n && !r_prev.mem_read_n) ||
                      (r_ctl.lines.mem_write_n && !r_prev.mem_write_n);
        w_any_fall  = w_ior_fall || w_iow_fall || w_memr_fall || w_memw_fall;
    end

    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_start     = r_start;
        n_early     = r_early;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_captured  = r_captured;
        n_waits     = r_waits;
        n_clocks    = r_clocks;
        n_fault     = r_fault;
        n_prev      = r_ctl.lines;
        w_cnt       = 2'd0;
        w_recs[0]   = '0;
        w_recs[1]   = '0;
        w_cyc_data  = '0;

        case (r_phase)
            PH_T1: begin
                if (w_ale_fall) begin
                    n_held_addr = r_early & w_amask;
                end
                if (w_any_fall && (r_type == isa_bcd_pkg::TYPE_NONE)) begin
                    if (w_ior_fall) begin
                        n_type = type_code(isa_bcd_pkg::TYPE_IO_RD_B, i_cfg.wide_data_en, w_sbhe);
                    end else if (w_iow_fall) begin
                        n_type = type_code(isa_bcd_pkg::TYPE_IO_WR_B, i_cfg.wide_data_en, w_sbhe);
                    end else if (w_memr_fall) begin
                        n_type = type_code(isa_bcd_pkg::TYPE_MEM_RD_B, i_cfg.wide_data_en,
                                           w_sbhe);
                    end else begin
                        n_type = type_code(isa_bcd_pkg::TYPE_MEM_WR_B, i_cfg.wide_data_en,
                                           w_sbhe);
                    end
                end
                if (w_clk_rise) begin
                    n_phase  = PH_T2;
                    n_clocks = isa_bcd_pkg::sat_inc(r_clocks);
                end
            end
            PH_T2: begin
                if (w_clk_rise) begin
                    n_clocks = isa_bcd_pkg::sat_inc(r_clocks);
                    if (!r_ctl.channel_ready) begin
                        n_phase = PH_TW;
                    end else begin
                        if (isa_bcd_pkg::is_write_type(r_type)) begin
                            n_held_data = w_data;
                            n_captured  = 1'b1;
                        end
                        n_phase = PH_T3;
                    end
                end
            end
            PH_TW: begin
                if (w_clk_rise) begin
                    n_clocks = isa_bcd_pkg::sat_inc(r_clocks);
                    n_waits  = isa_bcd_pkg::sat_inc(r_waits);
                    if (r_ctl.channel_ready) begin
                        n_phase = PH_T3;
                    end
                end
                // too many wait states: flag and force T3
                if (n_waits > i_cfg.wait_limit) begin
                    n_fault = 1'b1;
                    n_phase = PH_T3;
                end
            end
            PH_T3: begin
                if (w_clk_rise) begin
                    n_clocks = isa_bcd_pkg::sat_inc(r_clocks);
                    if (isa_bcd_pkg::is_read_type(r_type) && !r_captured) begin
                        n_held_data = w_data;
                        n_captured  = 1'b1;
                    end
                end
                if (w_cmd_rise) begin
                    if (isa_bcd_pkg::is_word_type(r_type)) begin
                        w_cyc_data = n_captured ? n_held_data : {DATA_BITS{1'b1}};
                    end else begin
                        w_cyc_data = n_captured ? (n_held_data & BYTE_MASK) : BYTE_MASK;
                    end
                    w_recs[0] = pack_rec(isa_bcd_pkg::KIND_CYCLE, r_type, r_start,
                                         n_held_addr, w_cyc_data, n_waits, n_clocks, n_fault);
                    w_cnt   = 2'd1;
                    n_phase = PH_IDLE;
                    n_type  = isa_bcd_pkg::TYPE_NONE;
                end
                if (n_clocks > i_cfg.cycle_limit) begin
                    n_fault = 1'b1;
                    w_recs[w_cnt[0]] = pack_rec(isa_bcd_pkg::KIND_TIMEOUT, n_type, r_start,
                                                n_held_addr, '0, n_waits, n_clocks, 1'b1);
                    w_cnt   = w_cnt + 2'd1;
                    n_phase = PH_IDLE;
                    n_type  = isa_bcd_pkg::TYPE_NONE;
                end
            end
            PH_REFRESH: begin
                if (w_clk_rise) begin
                    n_clocks = isa_bcd_pkg::sat_inc(r_clocks);
                end
                if (w_ref_rise) begin
                    w_recs[0] = pack_rec(isa_bcd_pkg::KIND_CYCLE, isa_bcd_pkg::TYPE_REFRESH,
                                         r_start, r_held_addr, '0, r_waits, n_clocks, 1'b0);
                    w_cnt   = 2'd1;
                    n_phase = PH_IDLE;
                    n_type  = isa_bcd_pkg::TYPE_NONE;
                end
                if (n_clocks > i_cfg.cycle_limit) begin
                    n_fault = 1'b1;
                    w_recs[w_cnt[0]] = pack_rec(isa_bcd_pkg::KIND_TIMEOUT, n_type, r_start,
                                                r_held_addr, '0, r_waits, n_clocks, 1'b1);
                    w_cnt   = w_cnt + 2'd1;
                    n_phase = PH_IDLE;
                    n_type  = isa_bcd_pkg::TYPE_NONE;
                end
            end
            default: begin
                // idle, and any code that means nothing
                n_phase = PH_IDLE;
                if (r_ctl.bus_reset) begin
                    // reset sample leaves the edge history untouched
                    w_recs[0] = pack_rec(isa_bcd_pkg::KIND_RESET, isa_bcd_pkg::TYPE_NONE,
                                         r_sample, '0, '0, '0, '0, 1'b0);
                    w_cnt  = 2'd1;
                    n_prev = r_prev;
                end else if (w_ale_rise || w_any_fall || w_ref_fall) begin
                    n_start    = r_sample;
                    n_phase    = PH_T1;
                    n_waits    = '0;
                    n_clocks   = '0;
                    n_fault    = 1'b0;
                    n_captured = 1'b0;
                    n_early    = r_addr & w_amask;
                    if (!r_ctl.lines.refresh_n) begin
                        n_phase = PH_REFRESH;
                        n_type  = isa_bcd_pkg::TYPE_REFRESH;
                    end else if (!r_ctl.lines.io_read_n) begin
                        n_type = type_code(isa_bcd_pkg::TYPE_IO_RD_B, i_cfg.wide_data_en, w_sbhe);
                    end else if (!r_ctl.lines.io_write_n) begin
                        n_type = type_code(isa_bcd_pkg::TYPE_IO_WR_B, i_cfg.wide_data_en, w_sbhe);
                    end else if (!r_ctl.lines.mem_read_n) begin
                        n_type = type_code(isa_bcd_pkg::TYPE_MEM_RD_B, i_cfg.wide_data_en,
                                           w_sbhe);
                    end else if (!r_ctl.lines.mem_write_n) begin
                        n_type = type_code(isa_bcd_pkg::TYPE_MEM_WR_B, i_cfg.wide_data_en,
                                           w_sbhe);
                    end else begin
                        n_type = isa_bcd_pkg::TYPE_NONE;
                    end
                end
            end
        endcase

        // mark the final record of this sample
        if (w_cnt == 2'd2) begin
            w_recs[1][0] = 1'b1;
        end else if (w_cnt == 2'd1) begin
            w_recs[0][0] = 1'b1;
        end
    end

    assign o_push_cnt = w_fire ? w_cnt : 2'd0;
    assign o_rec0     = w_recs[0];
    assign o_rec1     = w_recs[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_type      <= isa_bcd_pkg::TYPE_NONE;
            r_start     <= '0;
            r_sample    <= '0;
            r_early     <= '0;
            r_held_addr <= '0;
            r_held_data <= '0;
            r_captured  <= 1'b0;
            r_waits     <= '0;
            r_clocks    <= '0;
            r_fault     <= 1'b0;
            r_prev      <= '0;
        end else if (w_fire) begin
            r_phase     <= n_phase;
            r_type      <= n_type;
            r_start     <= n_start;
            r_sample    <= r_sample + 1'b1;
            r_early     <= n_early;
            r_held_addr <= n_held_addr;
            r_held_data <= n_held_data;
            r_captured  <= n_captured;
            r_waits     <= n_waits;
            r_clocks    <= n_clocks;
            r_fault     <= n_fault;
            r_prev      <= n_prev;
        end
    end

endmodule

[design/isa_bcd_outq.sv]
// Four-entry record queue between the decoder core and the output channel.
// Takes up to two records per cycle, hands out one. No package dependencies.
`timescale 1ns / 1ps

module isa_bcd_outq #(
    parameter int REC_W = 100
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  logic [REC_W-1:0] i_rec0,
    input  logic [REC_W-1:0] i_rec1,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [REC_W-1:0] o_rec
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic [REC_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;
    // room for the largest burst of one sample
    assign o_space = (r_count <= (PTR_W + 1)'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_rec0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + 1'b1] <= i_rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push_cnt);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PTR_W + 1)'(i_push_cnt) - (PTR_W + 1)'(w_pop);
        end
    end

endmodule

[design/isa_bus_cycle_decoder.sv]
// Top level of the ISA bus cycle decoder: config registers, decoder core, record queue.
// Depends on isa_bcd_pkg, the isa_bcd interfaces, isa_bcd_cfg, isa_bcd_core, isa_bcd_outq.
//
//   Channel  Dir  Transaction   Payload
//   i_in     in   bus sample    strobes, levels, address_lines, data_lines
//   o_out    out  bus record    kind, type, start index, address, data, counts, flags
//   i_cfg    in   reg write     index (0..3), data (8 bits)
//
// One sample is taken per clock unless the input stalls. A sample sits in the input
// register while the state machine decodes it and writes up to two records into a
// four-entry queue; the first record can be taken the cycle after. The input stalls only
// while the queue has fewer than two free entries. Reset (synchronous, active low) returns
// to idle with sample index zero and the default limits; no clearing pass is needed.
`timescale 1ns / 1ps

module isa_bus_cycle_decoder #(
    parameter int ADDRESS_BITS = 24,
    parameter int DATA_BITS    = 16,
    parameter int INDEX_BITS   = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    isa_bcd_in_if.sink    i_in,
    isa_bcd_out_if.source o_out,
    isa_bcd_cfg_if.sink   i_cfg
);

    localparam int REC_W = 2 + 4 + INDEX_BITS + ADDRESS_BITS + DATA_BITS + 8 + 8 + 1 + 1;

    isa_bcd_pkg::t_cfg w_cfg;
    isa_bcd_pkg::t_ctl w_ctl;
    logic              w_space;
    logic [1:0]        w_push_cnt;
    logic [REC_W-1:0]  w_rec0;
    logic [REC_W-1:0]  w_rec1;
    logic [REC_W-1:0]  w_head;

    assign w_ctl.lines.bus_clock   = i_in.bus_clock;
    assign w_ctl.lines.ale         = i_in.addr_latch_enable;
    assign w_ctl.lines.io_read_n   = i_in.io_read_n;
    assign w_ctl.lines.io_write_n  = i_in.io_write_n;
    assign w_ctl.lines.mem_read_n  = i_in.mem_read_n;
    assign w_ctl.lines.mem_write_n = i_in.mem_write_n;
    assign w_ctl.lines.refresh_n   = i_in.refresh_n;
    assign w_ctl.byte_high_enable_n = i_in.byte_high_enable_n;
    assign w_ctl.channel_ready     = i_in.channel_ready;
    assign w_ctl.bus_reset         = i_in.bus_reset;

    isa_bcd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_ready (i_cfg.ready),
        .o_cfg   (w_cfg)
    );

    isa_bcd_core #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .DATA_BITS    (DATA_BITS),
        .INDEX_BITS   (INDEX_BITS),
        .REC_W        (REC_W)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_ctl      (w_ctl),
        .i_addr     (i_in.address_lines),
        .i_data     (i_in.data_lines),
        .i_space    (w_space),
        .o_push_cnt (w_push_cnt),
        .o_rec0     (w_rec0),
        .o_rec1     (w_rec1)
    );

    isa_bcd_outq #(
        .REC_W (REC_W)
    ) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_rec0     (w_rec0),
        .i_rec1     (w_rec1),
        .o_space    (w_space),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_rec      (w_head)
    );

    assign {o_out.record_kind, o_out.cycle_type, o_out.start_index, o_out.latched_address,
            o_out.cycle_data, o_out.wait_count, o_out.clock_count, o_out.fault_flag,
            o_out.last_record} = w_head;

endmodule

[tb/testbench.sv]
// Self-checking testbench for isa_bus_cycle_decoder: streams bus samples, predicts records.
// Depends on isa_bcd_pkg, the isa_bcd channel interfaces and the design top level.
`timescale 1ns / 1ps

module testbench;

    localparam int ADDR_W     = 24;
    localparam int DATA_W     = 16;
    localparam int IDX_W      = 32;
    localparam int CYCLE_CAP  = 400000;
    localparam int PRINT_CAP  = 40;
    localparam int NO_CUT     = 1000;
    localparam int DRAIN_GAP  = 8;

    // width select codes the package leaves unnamed
    localparam logic [1:0] AW_SEL_16     = 2'd0;
    localparam logic [1:0] AW_SEL_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE, PH_T1, PH_T2, PH_WAIT, PH_T3, PH_REFRESH
    } t_bus_phase;

    typedef enum int {OP_IO_RD, OP_IO_WR, OP_MEM_RD, OP_MEM_WR} t_bus_op;

    typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} t_flow_mode;

    typedef struct packed {
        isa_bcd_pkg::t_ctl ctl;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_bus_sample;

    typedef struct packed {
        logic [1:0]        kind;
        logic [3:0]        ctype;
        logic [IDX_W-1:0]  start;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [7:0]        waits;
        logic [7:0]        clocks;
        logic              err;
        logic              last;
    } t_bus_record;

    logic i_clk = 1'b0;
    logic i_rst_n;

    isa_bcd_in_if #(.ADDRESS_BITS(ADDR_W), .DATA_BITS(DATA_W)) smp_bus ();
    isa_bcd_out_if #(.ADDRESS_BITS(ADDR_W), .DATA_BITS(DATA_W), .INDEX_BITS(IDX_W)) rec_bus ();
    isa_bcd_cfg_if reg_bus ();

    isa_bus_cycle_decoder #(
        .ADDRESS_BITS(ADDR_W),
        .DATA_BITS   (DATA_W),
        .INDEX_BITS  (IDX_W)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (smp_bus),
        .o_out  (rec_bus),
        .i_cfg  (reg_bus)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // decoder state as the testbench sees it
    isa_bcd_pkg::t_cfg     reg_model;
    t_bus_phase            bus_phase;
    logic [3:0]            cur_type;
    logic [IDX_W-1:0]      start_idx;
    logic [IDX_W-1:0]      sample_count;
    logic [ADDR_W-1:0]     early_addr;
    logic [ADDR_W-1:0]     held_addr;
    logic [DATA_W-1:0]     held_data;
    logic                  captured;
    logic [7:0]            waits_seen;
    logic [7:0]            clocks_seen;
    logic                  fault_seen;
    isa_bcd_pkg::t_strobes prev_lines;

    t_bus_record bus_records_due[$];

    int items_sent       = 0;
    int records_checked  = 0;
    int mismatches       = 0;
    int settings_applied = 0;
    int kind_tally[3]    = '{0, 0, 0};
    int cycle_count      = 0;
    int src_idle_pct     = 0;
    int sink_stall_pct   = 0;

    function automatic void reset_model();
        reg_model.addr_width_sel = AW_SEL_16;
        reg_model.wide_data_en   = 1'b0;
        reg_model.wait_limit     = isa_bcd_pkg::WAIT_LIMIT_RST;
        reg_model.cycle_limit    = isa_bcd_pkg::CYCLE_LIMIT_RST;
        bus_phase    = PH_IDLE;
        cur_type     = isa_bcd_pkg::TYPE_NONE;
        start_idx    = '0;
        sample_count = '0;
        early_addr   = '0;
        held_addr    = '0;
        held_data    = '0;
        captured     = 1'b0;
        waits_seen   = '0;
        clocks_seen  = '0;
        fault_seen   = 1'b0;
        prev_lines   = '0;
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic reads_bus(input logic [3:0] t);
        return t inside {isa_bcd_pkg::TYPE_IO_RD_B, isa_bcd_pkg::TYPE_IO_RD_W,
                         isa_bcd_pkg::TYPE_MEM_RD_B, isa_bcd_pkg::TYPE_MEM_RD_W};
    endfunction

    function automatic logic writes_bus(input logic [3:0] t);
        return t inside {isa_bcd_pkg::TYPE_IO_WR_B, isa_bcd_pkg::TYPE_IO_WR_W,
                         isa_bcd_pkg::TYPE_MEM_WR_B, isa_bcd_pkg::TYPE_MEM_WR_W};
    endfunction

    function automatic logic moves_word(input logic [3:0] t);
        return t inside {isa_bcd_pkg::TYPE_IO_RD_W, isa_bcd_pkg::TYPE_IO_WR_W,
                         isa_bcd_pkg::TYPE_MEM_RD_W, isa_bcd_pkg::TYPE_MEM_WR_W};
    endfunction

    function automatic logic [3:0] pick_type(input logic [3:0] byte_code, input logic sbhe);
        return (reg_model.wide_data_en && sbhe) ? byte_code + 4'd1 : byte_code;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_mask();
        case (reg_model.addr_width_sel)
            isa_bcd_pkg::AW_SEL_20: return 24'h0F_FFFF;
            isa_bcd_pkg::AW_SEL_24: return 24'hFF_FFFF;
            default:                return 24'h00_FFFF;
        endcase
    endfunction

    function automatic t_bus_record make_record(
        input logic [1:0] kind, input logic [3:0] ctype, input logic [IDX_W-1:0] start,
        input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data,
        input logic [7:0] waits, input logic [7:0] clocks, input logic err);
        t_bus_record r;
        r.kind   = kind;
        r.ctype  = ctype;
        r.start  = start;
        r.addr   = addr;
        r.data   = data;
        r.waits  = waits;
        r.clocks = clocks;
        r.err    = err;
        r.last   = 1'b0;
        return r;
    endfunction

    // Advance the decoder state by one sample and queue the records it produces.
    function automatic void decode_bus_sample(input t_bus_sample s);
        t_bus_record           made[2];
        int                    n;
        isa_bcd_pkg::t_strobes now;
        isa_bcd_pkg::t_strobes was;
        logic [IDX_W-1:0]      idx;
        logic [ADDR_W-1:0]     amask;
        logic [DATA_W-1:0]     dval;
        logic [DATA_W-1:0]     cdata;
        logic                  sbhe, rdy, keep_prev;
        logic                  clk_rise, ale_rise, ale_fall, ref_fall, ref_rise, cmd_rise;
        logic                  ior_fall, iow_fall, memr_fall, memw_fall, any_fall;
        n         = 0;
        keep_prev = 1'b0;
        now       = s.ctl.lines;
        was       = prev_lines;
        idx       = sample_count;
        sample_count = sample_count + 1'b1;
        amask = addr_mask();
        dval  = reg_model.wide_data_en ? s.data : {8'h00, s.data[7:0]};
        sbhe  = ~s.ctl.byte_high_enable_n;
        rdy   = s.ctl.channel_ready;

        clk_rise  = now.bus_clock & ~was.bus_clock;
        ale_rise  = now.ale & ~was.ale;
        ale_fall  = ~now.ale & was.ale;
        ior_fall  = ~now.io_read_n & was.io_read_n;
        iow_fall  = ~now.io_write_n & was.io_write_n;
        memr_fall = ~now.mem_read_n & was.mem_read_n;
        memw_fall = ~now.mem_write_n & was.mem_write_n;
        ref_fall  = ~now.refresh_n & was.refresh_n;
        ref_rise  = now.refresh_n & ~was.refresh_n;
        cmd_rise  = (now.io_read_n & ~was.io_read_n) | (now.io_write_n & ~was.io_write_n) |
                    (now.mem_read_n & ~was.mem_read_n) | (now.mem_write_n & ~was.mem_write_n);
        any_fall  = ior_fall | iow_fall | memr_fall | memw_fall;

        case (bus_phase)
            PH_T1: begin
                if (ale_fall) held_addr = early_addr & amask;
                if (any_fall && cur_type == isa_bcd_pkg::TYPE_NONE) begin
                    if (ior_fall)       cur_type = pick_type(isa_bcd_pkg::TYPE_IO_RD_B, sbhe);
                    else if (iow_fall)  cur_type = pick_type(isa_bcd_pkg::TYPE_IO_WR_B, sbhe);
                    else if (memr_fall) cur_type = pick_type(isa_bcd_pkg::TYPE_MEM_RD_B, sbhe);
                    else                cur_type = pick_type(isa_bcd_pkg::TYPE_MEM_WR_B, sbhe);
                end
                if (clk_rise) begin
                    bus_phase   = PH_T2;
                    clocks_seen = bump(clocks_seen);
                end
            end
            PH_T2: begin
                if (clk_rise) begin
                    clocks_seen = bump(clocks_seen);
                    if (!rdy) begin
                        bus_phase = PH_WAIT;
                    end else begin
                        if (writes_bus(cur_type)) begin
                            held_data = dval;
                            captured  = 1'b1;
                        end
                        bus_phase = PH_T3;
                    end
                end
            end
            PH_WAIT: begin
                if (clk_rise) begin
                    clocks_seen = bump(clocks_seen);
                    waits_seen  = bump(waits_seen);
                    if (rdy) bus_phase = PH_T3;
                end
                // too many wait states: flag the cycle and push it on to T3
                if (waits_seen > reg_model.wait_limit) begin
                    fault_seen = 1'b1;
                    bus_phase  = PH_T3;
                end
            end
            PH_T3: begin
                if (clk_rise) begin
                    clocks_seen = bump(clocks_seen);
                    if (reads_bus(cur_type) && !captured) begin
                        held_data = dval;
                        captured  = 1'b1;
                    end
                end
                if (cmd_rise) begin
                    if (moves_word(cur_type)) cdata = captured ? held_data : 16'hFFFF;
                    else cdata = captured ? {8'h00, held_data[7:0]} : 16'h00FF;
                    made[n] = make_record(isa_bcd_pkg::KIND_CYCLE, cur_type, start_idx,
                                          held_addr, cdata, waits_seen, clocks_seen,
                                          fault_seen);
                    n++;
                    bus_phase = PH_IDLE;
                    cur_type  = isa_bcd_pkg::TYPE_NONE;
                end
                if (clocks_seen > reg_model.cycle_limit) begin
                    fault_seen = 1'b1;
                    made[n] = make_record(isa_bcd_pkg::KIND_TIMEOUT, cur_type, start_idx,
                                          held_addr, '0, waits_seen, clocks_seen, 1'b1);
                    n++;
                    bus_phase = PH_IDLE;
                    cur_type  = isa_bcd_pkg::TYPE_NONE;
                end
            end
            PH_REFRESH: begin
                if (clk_rise) clocks_seen = bump(clocks_seen);
                if (ref_rise) begin
                    made[n] = make_record(isa_bcd_pkg::KIND_CYCLE, isa_bcd_pkg::TYPE_REFRESH,
                                          start_idx, held_addr, '0, waits_seen, clocks_seen,
                                          1'b0);
                    n++;
                    bus_phase = PH_IDLE;
                    cur_type  = isa_bcd_pkg::TYPE_NONE;
                end
                if (clocks_seen > reg_model.cycle_limit) begin
                    fault_seen = 1'b1;
                    made[n] = make_record(isa_bcd_pkg::KIND_TIMEOUT, cur_type, start_idx,
                                          held_addr, '0, waits_seen, clocks_seen, 1'b1);
                    n++;
                    bus_phase = PH_IDLE;
                    cur_type  = isa_bcd_pkg::TYPE_NONE;
                end
            end
            default: begin
                bus_phase = PH_IDLE;
                if (s.ctl.bus_reset) begin
                    // a reset sample leaves the edge history untouched
                    made[0]   = make_record(isa_bcd_pkg::KIND_RESET, isa_bcd_pkg::TYPE_NONE,
                                            idx, '0, '0, '0, '0, 1'b0);
                    n         = 1;
                    keep_prev = 1'b1;
                end else if (ale_rise | any_fall | ref_fall) begin
                    start_idx   = idx;
                    bus_phase   = PH_T1;
                    waits_seen  = '0;
                    clocks_seen = '0;
                    fault_seen  = 1'b0;
                    captured    = 1'b0;
                    early_addr  = s.addr & amask;
                    if (!now.refresh_n) begin
                        bus_phase = PH_REFRESH;
                        cur_type  = isa_bcd_pkg::TYPE_REFRESH;
                    end else if (!now.io_read_n) begin
                        cur_type = pick_type(isa_bcd_pkg::TYPE_IO_RD_B, sbhe);
                    end else if (!now.io_write_n) begin
                        cur_type = pick_type(isa_bcd_pkg::TYPE_IO_WR_B, sbhe);
                    end else if (!now.mem_read_n) begin
                        cur_type = pick_type(isa_bcd_pkg::TYPE_MEM_RD_B, sbhe);
                    end else if (!now.mem_write_n) begin
                        cur_type = pick_type(isa_bcd_pkg::TYPE_MEM_WR_B, sbhe);
                    end else begin
                        cur_type = isa_bcd_pkg::TYPE_NONE;
                    end
                end
            end
        endcase

        if (!keep_prev) prev_lines = now;
        if (n > 0) made[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) bus_records_due = {bus_records_due, made[i]};
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("record %0d %s: got 0x%0h, expected 0x%0h",
                                      records_checked, name, got, want));
    endtask

    always @(posedge i_clk) begin : check_records
        t_bus_record want;
        if (i_rst_n === 1'b1 && rec_bus.valid === 1'b1 && rec_bus.ready === 1'b1) begin
            if (bus_records_due.size() == 0) begin
                report_mismatch($sformatf("record kind %0d type %0d with nothing due",
                                          rec_bus.record_kind, rec_bus.cycle_type));
            end else begin
                want = bus_records_due.pop_front();
                compare_field("record_kind", 32'(rec_bus.record_kind), 32'(want.kind));
                compare_field("cycle_type", 32'(rec_bus.cycle_type), 32'(want.ctype));
                compare_field("start_index", rec_bus.start_index, want.start);
                compare_field("latched_address", 32'(rec_bus.latched_address),
                              32'(want.addr));
                compare_field("cycle_data", 32'(rec_bus.cycle_data), 32'(want.data));
                compare_field("wait_count", 32'(rec_bus.wait_count), 32'(want.waits));
                compare_field("clock_count", 32'(rec_bus.clock_count), 32'(want.clocks));
                compare_field("fault_flag", 32'(rec_bus.fault_flag), 32'(want.err));
                compare_field("last_record", 32'(rec_bus.last_record), 32'(want.last));
                if (want.kind <= isa_bcd_pkg::KIND_TIMEOUT) kind_tally[want.kind]++;
            end
            records_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("Timed out after %0d cycles, %0d records still due",
                     cycle_count, bus_records_due.size());
            $display("** isa_bus_cycle_decoder: FAILED **");
            $finish;
        end
    end

    always @(negedge i_clk) rec_bus.ready <= ($urandom_range(99) >= sink_stall_pct);

    task automatic set_flow(input t_flow_mode m);
        case (m)
            FLOW_SRC_IDLE:   begin src_idle_pct = 82; sink_stall_pct = 0;  end
            FLOW_SINK_STALL: begin src_idle_pct = 0;  sink_stall_pct = 82; end
            FLOW_BOTH:       begin src_idle_pct = 24; sink_stall_pct = 24; end
            default:         begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        endcase
    endtask

    // Entered and left at a falling edge; valid stays high for a back-to-back sample.
    task automatic send_sample(input t_bus_sample s);
        while ($urandom_range(99) < src_idle_pct) begin
            smp_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_bus.valid              <= 1'b1;
        smp_bus.bus_clock          <= s.ctl.lines.bus_clock;
        smp_bus.addr_latch_enable  <= s.ctl.lines.ale;
        smp_bus.io_read_n          <= s.ctl.lines.io_read_n;
        smp_bus.io_write_n         <= s.ctl.lines.io_write_n;
        smp_bus.mem_read_n         <= s.ctl.lines.mem_read_n;
        smp_bus.mem_write_n        <= s.ctl.lines.mem_write_n;
        smp_bus.refresh_n          <= s.ctl.lines.refresh_n;
        smp_bus.byte_high_enable_n <= s.ctl.byte_high_enable_n;
        smp_bus.channel_ready      <= s.ctl.channel_ready;
        smp_bus.bus_reset          <= s.ctl.bus_reset;
        smp_bus.address_lines      <= s.addr;
        smp_bus.data_lines         <= s.data;
        @(posedge i_clk);
        while (smp_bus.ready !== 1'b1) @(posedge i_clk);
        decode_bus_sample(s);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every due record, then give the pipeline time to empty.
    task automatic settle();
        smp_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (bus_records_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [isa_bcd_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [isa_bcd_pkg::CFG_DATA_W-1:0] value);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.data  <= value;
        @(posedge i_clk);
        while (reg_bus.ready !== 1'b1) @(posedge i_clk);
        case (idx)
            isa_bcd_pkg::REG_ADDR_WIDTH_SEL: reg_model.addr_width_sel = value[1:0];
            isa_bcd_pkg::REG_WIDE_DATA_EN:   reg_model.wide_data_en   = value[0];
            isa_bcd_pkg::REG_WAIT_LIMIT:     reg_model.wait_limit     = value;
            isa_bcd_pkg::REG_CYCLE_LIMIT:    reg_model.cycle_limit    = value;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [1:0] sel, input logic wide,
                                  input logic [7:0] wait_lim, input logic [7:0] cycle_lim);
        logic [7:0] v;
        settle();
        // junk in the unused upper bits must be ignored
        v = 8'($urandom);
        v[1:0] = sel;
        write_register(isa_bcd_pkg::REG_ADDR_WIDTH_SEL, v);
        v = 8'($urandom);
        v[0] = wide;
        write_register(isa_bcd_pkg::REG_WIDE_DATA_EN, v);
        write_register(isa_bcd_pkg::REG_WAIT_LIMIT, wait_lim);
        write_register(isa_bcd_pkg::REG_CYCLE_LIMIT, cycle_lim);
        reg_bus.valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic t_bus_sample quiet_sample(input logic word);
        t_bus_sample s;
        s.ctl.lines.bus_clock    = 1'b0;
        s.ctl.lines.ale          = 1'b0;
        s.ctl.lines.io_read_n    = 1'b1;
        s.ctl.lines.io_write_n   = 1'b1;
        s.ctl.lines.mem_read_n   = 1'b1;
        s.ctl.lines.mem_write_n  = 1'b1;
        s.ctl.lines.refresh_n    = 1'b1;
        s.ctl.byte_high_enable_n = ~word;
        s.ctl.channel_ready      = 1'b1;
        s.ctl.bus_reset          = 1'b0;
        s.addr = ADDR_W'($urandom);
        s.data = DATA_W'($urandom);
        return s;
    endfunction

    function automatic t_bus_sample busy_sample(input t_bus_op op, input logic word,
                                                input logic clk, input logic rdy);
        t_bus_sample s;
        s = quiet_sample(word);
        case (op)
            OP_IO_RD:  s.ctl.lines.io_read_n   = 1'b0;
            OP_IO_WR:  s.ctl.lines.io_write_n  = 1'b0;
            OP_MEM_RD: s.ctl.lines.mem_read_n  = 1'b0;
            default:   s.ctl.lines.mem_write_n = 1'b0;
        endcase
        s.ctl.lines.bus_clock = clk;
        s.ctl.channel_ready   = rdy;
        return s;
    endfunction

    function automatic t_bus_sample noise_sample();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_bus_sample)-1:0];
    endfunction

    // One bus cycle: ALE, strobe, T1/T2, wait states, clock edges in T3, strobe release.
    // Only the first cut samples go out, which models a cycle broken off early.
    task automatic gen_bus_cycle(input t_bus_op op, input logic word, input int n_waits,
                                 input int n_t3, input bit with_ale, input bit strobe_early,
                                 input int cut);
        t_bus_sample seq[$];
        t_bus_sample s;
        seq = {seq, quiet_sample(word)};
        if (with_ale) begin
            s = strobe_early ? busy_sample(op, word, 1'b0, 1'b1) : quiet_sample(word);
            s.ctl.lines.ale = 1'b1;
            seq = {seq, s};
        end
        seq = {seq, busy_sample(op, word, 1'b0, 1'b1)};
        seq = {seq, busy_sample(op, word, 1'b1, 1'b1)};
        seq = {seq, busy_sample(op, word, 1'b0, 1'b1)};
        seq = {seq, busy_sample(op, word, 1'b1, n_waits == 0)};
        for (int i = 0; i < n_waits; i++) begin
            seq = {seq, busy_sample(op, word, 1'b0, 1'b0)};
            seq = {seq, busy_sample(op, word, 1'b1, i == n_waits - 1)};
        end
        for (int i = 0; i < n_t3; i++) begin
            seq = {seq, busy_sample(op, word, 1'b0, 1'b1)};
            seq = {seq, busy_sample(op, word, 1'b1, 1'b1)};
        end
        seq = {seq, quiet_sample(word)};
        for (int i = 0; i < seq.size() && i < cut; i++) send_sample(seq[i]);
    endtask

    task automatic gen_refresh(input int n_clocks);
        t_bus_sample s;
        send_sample(quiet_sample(1'($urandom_range(1))));
        s = quiet_sample(1'($urandom_range(1)));
        s.ctl.lines.refresh_n = 1'b0;
        send_sample(s);
        for (int i = 0; i < 2 * n_clocks; i++) begin
            s = quiet_sample(1'($urandom_range(1)));
            s.ctl.lines.refresh_n = 1'b0;
            s.ctl.lines.bus_clock = (i % 2 == 0);
            send_sample(s);
        end
        send_sample(quiet_sample(1'($urandom_range(1))));
    endtask

    // Steer the bus back to idle from wherever noise or a broken cycle left it.
    task automatic return_to_idle();
        t_bus_sample s;
        while (bus_phase != PH_IDLE) begin
            s = quiet_sample(1'($urandom_range(1)));
            case (bus_phase)
                PH_T3: begin
                    if (prev_lines.io_read_n & prev_lines.io_write_n &
                        prev_lines.mem_read_n & prev_lines.mem_write_n) begin
                        s.ctl.lines.io_read_n   = 1'b0;
                        s.ctl.lines.io_write_n  = 1'b0;
                        s.ctl.lines.mem_read_n  = 1'b0;
                        s.ctl.lines.mem_write_n = 1'b0;
                    end
                end
                PH_REFRESH: s.ctl.lines.refresh_n = ~prev_lines.refresh_n;
                default:    s.ctl.lines.bus_clock = ~prev_lines.bus_clock;
            endcase
            send_sample(s);
        end
    endtask

    task automatic run_traffic(input int n_items);
        int goal;
        int pick;
        int n_waits;
        int n_t3;
        t_bus_sample s;
        for (int q = 0; q < 4; q++) begin
            set_flow(t_flow_mode'(q));
            goal = items_sent + n_items / 4;
            while (items_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 15) begin
                    repeat ($urandom_range(1, 6)) send_sample(noise_sample());
                end else begin
                    return_to_idle();
                    if (pick < 25) begin
                        gen_refresh($urandom_range(0, 13));
                    end else if (pick < 30) begin
                        repeat ($urandom_range(1, 3)) begin
                            s = noise_sample();
                            s.ctl.bus_reset = 1'b1;
                            send_sample(s);
                        end
                    end else begin
                        pick = $urandom_range(9);
                        if (pick < 4)      n_waits = 0;
                        else if (pick < 8) n_waits = $urandom_range(1, 3);
                        else               n_waits = $urandom_range(4, 24);
                        n_t3 = ($urandom_range(9) < 8) ? 1 : $urandom_range(0, 12);
                        gen_bus_cycle(t_bus_op'($urandom_range(3)), 1'($urandom_range(1)),
                                      n_waits, n_t3, $urandom_range(9) != 0,
                                      $urandom_range(3) == 0,
                                      ($urandom_range(9) == 0) ? $urandom_range(1, 6)
                                                               : NO_CUT);
                    end
                end
            end
        end
    endtask

    task automatic test_directed_cycles();
        t_bus_sample s;
        apply_settings(isa_bcd_pkg::AW_SEL_24, 1'b1, isa_bcd_pkg::WAIT_LIMIT_RST,
                       isa_bcd_pkg::CYCLE_LIMIT_RST);
        set_flow(FLOW_FREE);
        s = quiet_sample(1'b0);
        s.ctl.bus_reset = 1'b1;
        send_sample(s);
        s = '1;
        send_sample(s);
        s = '0;
        send_sample(s);
        gen_bus_cycle(OP_IO_RD, 1'b1, 1, 1, 1'b1, 1'b0, NO_CUT);
        gen_bus_cycle(OP_MEM_WR, 1'b0, 0, 1, 1'b1, 1'b1, NO_CUT);
        gen_refresh(2);
    endtask

    task automatic test_narrow_bus();
        apply_settings(AW_SEL_16, 1'b0, isa_bcd_pkg::WAIT_LIMIT_RST,
                       isa_bcd_pkg::CYCLE_LIMIT_RST);
        run_traffic(300);
    endtask

    task automatic test_zero_limits();
        apply_settings(isa_bcd_pkg::AW_SEL_20, 1'b1, 8'd0, 8'd0);
        run_traffic(240);
    endtask

    task automatic test_full_limits();
        apply_settings(AW_SEL_UNUSED, 1'b1, 8'hFF, 8'hFF);
        run_traffic(300);
    endtask

    task automatic test_random_settings();
        repeat (4) begin
            apply_settings(2'($urandom_range(3)), 1'($urandom_range(1)),
                           8'($urandom_range(0, 30)), 8'($urandom_range(2, 24)));
            run_traffic(180);
        end
    endtask

    initial begin
        i_rst_n                    = 1'b0;
        smp_bus.valid              = 1'b0;
        smp_bus.bus_clock          = 1'b0;
        smp_bus.addr_latch_enable  = 1'b0;
        smp_bus.io_read_n          = 1'b1;
        smp_bus.io_write_n         = 1'b1;
        smp_bus.mem_read_n         = 1'b1;
        smp_bus.mem_write_n        = 1'b1;
        smp_bus.refresh_n          = 1'b1;
        smp_bus.byte_high_enable_n = 1'b1;
        smp_bus.channel_ready      = 1'b1;
        smp_bus.bus_reset          = 1'b0;
        smp_bus.address_lines      = '0;
        smp_bus.data_lines         = '0;
        reg_bus.valid              = 1'b0;
        reg_bus.index              = '0;
        reg_bus.data               = '0;
        reset_model();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cycles();
        test_narrow_bus();
        test_zero_limits();
        test_full_limits();
        test_random_settings();

        set_flow(FLOW_FREE);
        settle();

        $display("Sent %0d bus samples under %0d register settings and four flow modes.",
                 items_sent, settings_applied);
        $display("Checked %0d records: %0d cycles, %0d timeouts, %0d resets; %0d mismatches.",
                 records_checked, kind_tally[isa_bcd_pkg::KIND_CYCLE],
                 kind_tally[isa_bcd_pkg::KIND_TIMEOUT], kind_tally[isa_bcd_pkg::KIND_RESET],
                 mismatches);
        if (mismatches == 0) begin
            $display("** isa_bus_cycle_decoder: PASSED **");
        end else begin
            $display("** isa_bus_cycle_decoder: FAILED **");
        end
        $finish;
    end

endmodule

[isa_bus_cycle_decoder.f]
design/isa_bcd_pkg.sv
design/isa_bcd_if.sv
design/isa_bcd_cfg.sv
design/isa_bcd_core.sv
design/isa_bcd_outq.sv
design/isa_bus_cycle_decoder.sv
tb/testbench.sv
